### sv/assert_macros.svh
// Assertion macros shared by the RTL of the altitude block.
// Depends on nothing; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/bac_pkg.sv
// Constants of the pressure altitude pipeline: polynomial coefficients,
// fixed-point scale factors and the register map. No dependencies.
package bac_pkg;

    localparam int unsigned DIV_STAGES = 32;
    localparam int unsigned POLY_STEPS = 4;
    localparam int unsigned ACC_W = 36;

    localparam logic signed [ACC_W-1:0] COEF [0:POLY_STEPS] = '{
        -36'sd11274289, 36'sd83751862, -36'sd264247863, 36'sd526455616, 36'sd739056497
    };

    localparam logic signed [ACC_W-1:0] ONE_Q30 = 36'sd1073741824;
    localparam logic signed [16:0] KELVIN_CENTI = 17'sd27315;
    localparam logic signed [67:0] SCALE_NUM = 68'sd10000;
    localparam logic [6:0] SCALE_DEN = 7'd65;
    // 65 * 2^21: any magnitude at or above this saturates
    localparam logic [27:0] Q_CLAMP = 28'd136314880;
    // floor(2^32 / 65)
    localparam logic [26:0] RECIP_65 = 27'd66076419;

    localparam logic [20:0] ALT_MAX = 21'h0FFFFF;
    localparam logic [20:0] ALT_MIN = 21'h100000;
    localparam logic [21:0] ALT_MAX_MAG = 22'd1048575;
    localparam logic [21:0] ALT_MIN_MAG = 22'd1048576;

    localparam logic [16:0] REF_RESET = 17'd101325;
    localparam logic [0:0] REG_REFERENCE = 1'b0;

endpackage

### sv/barometric_altitude_calc.sv
// Pressure altitude pipeline: divider, Horner polynomial and scaling.
// Depends on bac_pkg and assert_macros.svh.
//
// One item per cycle unless the output stalls. Registered steps in order: the
// restoring divider (one quotient bit per stage), ratio saturation, the
// polynomial (partial products, then sum per Horner step), and temperature
// scaling with the division by 65. The whole pipe advances unless a result
// waits at the output under stall.
`include "assert_macros.svh"

module barometric_altitude_calc import bac_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [16:0]        i_pressure_pa,
    input  logic signed [14:0] i_temperature_centi_c,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [20:0] o_altitude_cm,
    output logic               o_invalid,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [16:0] r_ref;
    logic        en;
    logic        r_ov;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REFERENCE) ? {15'd0, r_ref} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= REF_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_REFERENCE) begin
            r_ref <= pwdata[16:0];
        end
    end

    assign en = !r_ov || !i_out_stall;
    assign o_in_stall = !en;

    // divider
    logic               r_dv    [0:DIV_STAGES];
    logic [16:0]        r_drem  [0:DIV_STAGES];
    logic [16:0]        r_dp    [0:DIV_STAGES];
    logic [31:0]        r_dq    [0:DIV_STAGES];
    logic signed [14:0] r_dt    [0:DIV_STAGES];
    logic               r_dsat  [0:DIV_STAGES];
    logic               r_dzero [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_drem[0]  <= {2'b00, r_ref[16:2]};
            r_dp[0]    <= i_pressure_pa;
            r_dq[0]    <= 32'd0;
            r_dt[0]    <= i_temperature_centi_c;
            r_dsat[0]  <= {2'b00, r_ref} >= {i_pressure_pa, 2'b00};
            r_dzero[0] <= i_pressure_pa == 17'd0;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic        bit_in;
        logic [17:0] trial;
        logic        take;
        assign bit_in = (k == 0) ? r_ref[1] : ((k == 1) ? r_ref[0] : 1'b0);
        assign trial  = {r_drem[k], bit_in};
        assign take   = trial >= {1'b0, r_dp[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_drem[k+1]  <= take ? 17'(trial - {1'b0, r_dp[k]}) : trial[16:0];
                r_dp[k+1]    <= r_dp[k];
                r_dq[k+1]    <= {r_dq[k][30:0], take};
                r_dt[k+1]    <= r_dt[k];
                r_dsat[k+1]  <= r_dsat[k];
                r_dzero[k+1] <= r_dzero[k];
            end
        end
    end

    // polynomial
    logic                    r_hv  [0:POLY_STEPS];
    logic signed [ACC_W-1:0] r_acc [0:POLY_STEPS];
    logic [31:0]             r_hx  [0:POLY_STEPS];
    logic signed [14:0]      r_ht  [0:POLY_STEPS];
    logic                    r_hz  [0:POLY_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv[0] <= 1'b0;
        end else if (en) begin
            r_hv[0] <= r_dv[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_acc[0] <= COEF[0];
            r_hx[0]  <= r_dsat[DIV_STAGES] ? 32'hFFFF_FFFF : r_dq[DIV_STAGES];
            r_ht[0]  <= r_dt[DIV_STAGES];
            r_hz[0]  <= r_dzero[DIV_STAGES];
        end
    end

    for (genvar j = 0; j < POLY_STEPS; j++) begin : g_poly
        logic                    r_av;
        logic signed [52:0]      r_pl;
        logic signed [52:0]      r_ph;
        logic [31:0]             r_ax;
        logic signed [14:0]      r_at;
        logic                    r_az;
        logic signed [52:0]      n_pl;
        logic signed [52:0]      n_ph;
        logic signed [68:0]      sum;
        logic signed [68:0]      sum_rz;

        assign n_pl   = r_acc[j] * $signed({1'b0, r_hx[j][15:0]});
        assign n_ph   = r_acc[j] * $signed({1'b0, r_hx[j][31:16]});
        assign sum    = ($signed({{16{r_ph[52]}}, r_ph}) <<< 16) + 69'(r_pl);
        assign sum_rz = sum + (sum[68] ? 69'sd1073741823 : 69'sd0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av      <= 1'b0;
                r_hv[j+1] <= 1'b0;
            end else if (en) begin
                r_av      <= r_hv[j];
                r_hv[j+1] <= r_av;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pl       <= n_pl;
                r_ph       <= n_ph;
                r_ax       <= r_hx[j];
                r_at       <= r_ht[j];
                r_az       <= r_hz[j];
                r_acc[j+1] <= sum_rz[65:30] + COEF[j+1];
                r_hx[j+1]  <= r_ax;
                r_ht[j+1]  <= r_at;
                r_hz[j+1]  <= r_az;
            end
        end
    end

    // scaling
    logic                    r_f1v, r_f2v, r_f3v, r_f4v;
    logic signed [52:0]      r_yk;
    logic signed [67:0]      r_pw;
    logic [27:0]             r_qc3, r_qc4;
    logic [54:0]             r_prod;
    logic                    r_z1, r_z2, r_z3, r_z4, r_fz;
    logic                    r_neg3, r_neg4;
    logic signed [20:0]      r_alt;
    logic                    r_inv;

    logic signed [ACC_W-1:0] y;
    logic signed [16:0]      kel;
    logic                    neg2;
    logic [67:0]             mag;
    logic [37:0]             qfull;
    logic [27:0]             n_qc;
    logic [22:0]             q0;
    logic [27:0]             rem65;
    logic [21:0]             q;

    assign y     = r_acc[POLY_STEPS] - ONE_Q30;
    assign kel   = {{2{r_ht[POLY_STEPS][14]}}, r_ht[POLY_STEPS]} + KELVIN_CENTI;
    assign neg2  = r_pw[67];
    assign mag   = neg2 ? 68'(-r_pw) : 68'(r_pw);
    assign qfull = mag[67:30];
    assign n_qc  = (qfull >= {10'd0, Q_CLAMP}) ? Q_CLAMP : qfull[27:0];
    assign q0    = r_prod[54:32];
    assign rem65 = r_qc4 - ({5'd0, q0} * {21'd0, SCALE_DEN});
    assign q     = {1'b0, q0[20:0]} + ((rem65 >= {21'd0, SCALE_DEN}) ? 22'd1 : 22'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1v <= 1'b0;
            r_f2v <= 1'b0;
            r_f3v <= 1'b0;
            r_f4v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_f1v <= r_hv[POLY_STEPS];
            r_f2v <= r_f1v;
            r_f3v <= r_f2v;
            r_f4v <= r_f3v;
            r_ov  <= r_f4v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yk   <= y * kel;
            r_z1   <= r_hz[POLY_STEPS];
            r_pw   <= 68'(r_yk) * SCALE_NUM;
            r_z2   <= r_z1;
            r_qc3  <= n_qc;
            r_neg3 <= neg2;
            r_z3   <= r_z2;
            r_prod <= r_qc3 * RECIP_65;
            r_qc4  <= r_qc3;
            r_neg4 <= r_neg3;
            r_z4   <= r_z3;
            r_fz   <= r_z4;
            if (r_z4) begin
                r_alt <= 21'sd0;
                r_inv <= 1'b1;
            end else if (r_neg4) begin
                if (q > ALT_MIN_MAG) begin
                    r_alt <= ALT_MIN;
                    r_inv <= 1'b1;
                end else begin
                    r_alt <= 21'(-q);
                    r_inv <= 1'b0;
                end
            end else begin
                if (q > ALT_MAX_MAG) begin
                    r_alt <= ALT_MAX;
                    r_inv <= 1'b1;
                end else begin
                    r_alt <= q[20:0];
                    r_inv <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_altitude_cm = r_alt;
    assign o_invalid     = r_inv;

    `ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_in_stall, r_ov && i_out_stall, "input stalled without a waiting item")
    `ASSERT_NXT(a_out_holds, i_clk, i_rst_n, r_ov && i_out_stall, r_ov && $stable(r_alt) && $stable(r_inv), "waiting item changed")
    `ASSERT_IMP(a_zero_pressure, i_clk, i_rst_n, r_ov && r_fz, r_inv && r_alt == 21'sd0, "zero pressure item not flagged")

endmodule
